FILE: rtl/hre_pkg.sv
// Package: widths, register indexes, flag struct and constant functions for the Hill evaluator.
package hre_pkg;

   localparam int DATA_W          = 32;
   localparam int POWER_W         = 16;
   localparam int FRAC_BITS       = 16;
   localparam int POWER_FRAC_BITS = 12;
   localparam int LOG_BITS        = 24;
   localparam int PW              = 5;              // leading-one position, 0..30
   localparam int LOG_W           = LOG_BITS + 6;   // signed log2, Q6.LOG_BITS
   localparam int DM_W            = LOG_W + 1 + POWER_W - POWER_FRAC_BITS;
   localparam int IP_W            = DM_W - LOG_BITS;
   localparam int DIV_STEPS       = 32;
   localparam int DEN_W           = 64;
   localparam int CSR_IDX_W       = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE       = 3'd0,
      CSR_RESPONSE   = 3'd1,
      CSR_HALF_MAX   = 3'd2,
      CSR_HILL_POWER = 3'd3,
      CSR_INCREASING = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic s_zero;   // clamped signal is zero
      logic neg;      // log2 K < log2 s
      logic big;      // exponent term out of range
   } flags_type;

   // integer square root, bit pair per step
   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(2^-k) in Q1.31
   function automatic logic [31:0] exp2_const(input int k);
      logic [63:0] c;
      c = 64'h0000_0001_0000_0000;
      for (int j = 1; j <= LOG_BITS; j++) begin
         if (j <= k) begin
            c = isqrt64(c << 31);
         end
      end
      return c[31:0];
   endfunction

endpackage

FILE: rtl/hre_if.sv
// Interfaces: request and response channels of the Hill evaluator.
interface hre_req_if;
   import hre_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] signal_value;
   modport source (output valid, output signal_value, input ready);
   modport sink   (input valid, input signal_value, output ready);
endinterface

interface hre_rsp_if;
   import hre_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] behavior_value;
   modport source (output valid, output behavior_value, input ready);
   modport sink   (input valid, input behavior_value, output ready);
endinterface

FILE: rtl/hre_log2_lane.sv
// Pipelined bit-serial log2: normalise stage then one squaring stage per fraction bit.
module hre_log2_lane import hre_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [DATA_W-2:0] x,
   output logic [LOG_W-1:0] log_val
);

   logic [PW-1:0]       p_ff  [0:LOG_BITS];
   logic [DATA_W-1:0]   m_ff  [0:LOG_BITS];
   logic [LOG_BITS-1:0] fr_ff [0:LOG_BITS];
   logic [PW-1:0]       p_in;
   logic [DATA_W-1:0]   m_in;
   logic [5:0]          pf;

   always_comb begin
      p_in = '0;
      for (int i = 1; i < DATA_W - 1; i++) begin
         if (x[i]) begin
            p_in = PW'(i);
         end
      end
      m_in = {1'b0, x} << (PW'(DATA_W - 1) - p_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0]  <= p_in;
         m_ff[0]  <= m_in;
         fr_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= LOG_BITS; k++) begin : g_sq
      logic [2*DATA_W-1:0] sq;
      assign sq = 64'(m_ff[k-1]) * 64'(m_ff[k-1]);
      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[k]  <= p_ff[k-1];
            m_ff[k]  <= sq[63] ? sq[63:32] : sq[62:31];
            fr_ff[k] <= {fr_ff[k-1][LOG_BITS-2:0], sq[63]};
         end
      end
   end

   // integer part is a signed 6-bit field: leading-one position minus FRAC_BITS
   assign pf      = 6'({1'b0, p_ff[LOG_BITS]}) - 6'(FRAC_BITS);
   assign log_val = {pf, fr_ff[LOG_BITS]};

endmodule

FILE: rtl/hre_divider.sv
// Pipelined restoring divider: 2^63 / den, one quotient bit per stage.
module hre_divider import hre_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [DEN_W-1:0] den,
   output logic [31:0]      quot
);

   logic [DEN_W-1:0] rem_ff [1:DIV_STEPS];
   logic [DEN_W-1:0] den_ff [1:DIV_STEPS];
   logic [31:0]      q_ff   [1:DIV_STEPS];

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      logic [DEN_W-1:0] rem_p;
      logic [DEN_W-1:0] den_p;
      logic [31:0]      q_p;
      logic [DEN_W:0]   sh;
      logic             ge;
      if (k == 1) begin : g_first
         // top half of the dividend leaves remainder 2^31
         assign rem_p = DEN_W'(64'h8000_0000);
         assign den_p = den;
         assign q_p   = '0;
      end else begin : g_next
         assign rem_p = rem_ff[k-1];
         assign den_p = den_ff[k-1];
         assign q_p   = q_ff[k-1];
      end
      assign sh = {rem_p, 1'b0};
      assign ge = sh >= {1'b0, den_p};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? DEN_W'(sh - {1'b0, den_p}) : sh[DEN_W-1:0];
            den_ff[k] <= den_p;
            q_ff[k]   <= {q_p[30:0], ge};
         end
      end
   end

   assign quot = q_ff[DIV_STEPS];

endmodule

FILE: rtl/hill_response_evaluator_top.sv
// Top level: Hill response evaluator, fully pipelined log/exp2/divide datapath.
//
//  channel | dir | payload                       | handshake
//  req     | in  | signal_value   s32 Q16.16     | valid/ready
//  rsp     | out | behavior_value s32 Q16.16     | valid/ready
//  csr     | in  | 5 indexes 0..4, 4 stored      | write enable, no wait
//
//  One request per cycle sustained unless a held result stalls the pipeline; the datapath
//  has the 25-stage log2 lanes, the 24-stage exp2 chain and the 32-stage divider.
//  Reset clears the valid bits and the registers to their reset values.
//  The pipeline advances as a whole; it holds only when a result waits in the output
//  register and the last stage is full. Nothing is dropped or repeated on a hold.
//  The increasing bit does not change the result and is not stored.
module hill_response_evaluator_top import hre_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   hre_req_if.sink              req_chan,
   hre_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_idx,
   input  logic [DATA_W-1:0]    csr_wdata
);

   // stage map: log lanes 0..LOG_BITS, then diff, mul, exp2, den, divider, ratio, product
   localparam int D_IDX = LOG_BITS + 1;
   localparam int M_IDX = D_IDX + 1;
   localparam int N_IDX = M_IDX + LOG_BITS + 1;
   localparam int Q_END = N_IDX + DIV_STEPS;
   localparam int R_IDX = Q_END + 1;
   localparam int NST   = R_IDX + 2;

   // configuration
   logic signed [DATA_W-1:0] base_ff;
   logic signed [DATA_W-1:0] resp_ff;
   logic signed [DATA_W-1:0] half_ff;
   logic [POWER_W-1:0]       power_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         resp_ff  <= '0;
         half_ff  <= DATA_W'(1 << FRAC_BITS);
         power_ff <= POWER_W'(1 << POWER_FRAC_BITS);
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_idx))
            CSR_BASE:       base_ff  <= csr_wdata;
            CSR_RESPONSE:   resp_ff  <= csr_wdata;
            CSR_HALF_MAX:   half_ff  <= csr_wdata;
            CSR_HILL_POWER: power_ff <= csr_wdata[POWER_W-1:0];
            default: ;      // direction bit and unused indexes
         endcase
      end
   end

   // pipeline control
   logic           vld_ff [0:NST-1];
   logic           out_vld_ff;
   logic           adv;
   logic           take;

   assign take = !out_vld_ff || rsp_chan.ready;
   assign adv  = take || !vld_ff[NST-1];
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) begin
            vld_ff[i] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff[0] <= req_chan.valid;
            for (int i = 1; i < NST; i++) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
         if (take) begin
            out_vld_ff <= vld_ff[NST-1];
         end
      end
   end

   // log2 lanes: signal (clamped) and half-max
   logic [DATA_W-2:0] s_clamp;
   logic [LOG_W-1:0]  log_s;
   logic [LOG_W-1:0]  log_k;
   logic              sz_ff [0:LOG_BITS];

   assign s_clamp = req_chan.signal_value[DATA_W-1] ? '0 : req_chan.signal_value[DATA_W-2:0];

   hre_log2_lane u_log_s (.clock(clock), .en(adv), .x(s_clamp),             .log_val(log_s));
   hre_log2_lane u_log_k (.clock(clock), .en(adv), .x(half_ff[DATA_W-2:0]), .log_val(log_k));

   always_ff @(posedge clock) begin
      if (adv) begin
         sz_ff[0] <= (s_clamp == '0);
         for (int i = 1; i <= LOG_BITS; i++) begin
            sz_ff[i] <= sz_ff[i-1];
         end
      end
   end

   // difference of logs, magnitude and sign
   logic signed [LOG_W:0] ldiff;
   logic [LOG_W:0]        u_ff;
   flags_type             dfl_ff;

   assign ldiff = $signed({log_k[LOG_W-1], log_k}) - $signed({log_s[LOG_W-1], log_s});

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff   <= ldiff[LOG_W] ? (LOG_W+1)'(-ldiff) : ldiff;
         dfl_ff <= '{s_zero: sz_ff[LOG_BITS], neg: ldiff[LOG_W], big: 1'b0};
      end
   end

   // scale by exponent n, then exp2 of the fraction, one constant factor per stage
   logic [LOG_W+POWER_W:0] un;
   logic [DM_W-1:0]        dm;
   logic [31:0]            em_ff  [0:LOG_BITS];
   logic [LOG_BITS-1:0]    ef_ff  [0:LOG_BITS];
   logic [IP_W-1:0]        eip_ff [0:LOG_BITS];
   flags_type              efl_ff [0:LOG_BITS];

   assign un = (LOG_W+POWER_W+1)'(u_ff) * (LOG_W+POWER_W+1)'(power_ff);
   assign dm = un[LOG_W+POWER_W:POWER_FRAC_BITS];

   always_ff @(posedge clock) begin
      if (adv) begin
         em_ff[0]  <= 32'h8000_0000;
         ef_ff[0]  <= dm[LOG_BITS-1:0];
         eip_ff[0] <= dm[DM_W-1:LOG_BITS];
         efl_ff[0] <= dfl_ff;
      end
   end

   for (genvar k = 1; k <= LOG_BITS; k++) begin : g_exp
      localparam logic [31:0] CK = exp2_const(k);
      logic [63:0] pr;
      assign pr = 64'(em_ff[k-1]) * 64'(CK);
      always_ff @(posedge clock) begin
         if (adv) begin
            em_ff[k]  <= ef_ff[k-1][LOG_BITS-k] ? pr[62:31] : em_ff[k-1];
            ef_ff[k]  <= ef_ff[k-1];
            eip_ff[k] <= eip_ff[k-1];
            efl_ff[k] <= efl_ff[k-1];
         end
      end
   end

   // denominator 1 + 2^d in Q.31
   logic [DEN_W-1:0] den_ff;
   flags_type        nfl_ff;
   logic [31:0]      quot;
   flags_type        qfl_ff [1:DIV_STEPS];

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff <= DEN_W'(64'h8000_0000)
                   + (DEN_W'(em_ff[LOG_BITS]) << eip_ff[LOG_BITS][4:0]);
         nfl_ff <= '{s_zero: efl_ff[LOG_BITS].s_zero,
                     neg:    efl_ff[LOG_BITS].neg,
                     big:    (eip_ff[LOG_BITS] >= IP_W'(32))};
      end
   end

   hre_divider u_div (.clock(clock), .en(adv), .den(den_ff), .quot(quot));

   always_ff @(posedge clock) begin
      if (adv) begin
         qfl_ff[1] <= nfl_ff;
         for (int i = 2; i <= DIV_STEPS; i++) begin
            qfl_ff[i] <= qfl_ff[i-1];
         end
      end
   end

   // ratio in Q1.32
   logic [32:0] r_in;
   logic [32:0] r_ff;
   flags_type   fl;

   assign fl = qfl_ff[DIV_STEPS];

   always_comb begin
      priority if (fl.s_zero) begin
         r_in = (power_ff == '0) ? 33'h0_8000_0000 : '0;
      end else if (fl.big) begin
         r_in = fl.neg ? 33'h1_0000_0000 : '0;
      end else if (fl.neg) begin
         r_in = 33'h1_0000_0000 - 33'(quot);
      end else begin
         r_in = 33'(quot);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff <= r_in;
      end
   end

   // blend: |resp - base| * ratio
   logic signed [DATA_W:0] diff;
   logic [DATA_W:0]        mag;
   logic [65:0]            prod_ff;
   logic                   psign_ff;

   assign diff = $signed({resp_ff[DATA_W-1], resp_ff}) - $signed({base_ff[DATA_W-1], base_ff});
   assign mag  = diff[DATA_W] ? (DATA_W+1)'(-diff) : diff;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff  <= 66'(mag) * 66'(r_ff);
         psign_ff <= diff[DATA_W];
      end
   end

   // round half away from zero, add base, saturate; half-max not positive gives response
   logic [65:0]        rnd;
   logic signed [35:0] delta;
   logic signed [35:0] res;
   logic [DATA_W-1:0]  res_sat;
   logic [DATA_W-1:0]  out_ff;

   assign rnd   = prod_ff + 66'h0_8000_0000;
   assign delta = psign_ff ? -$signed({2'b00, rnd[65:32]}) : $signed({2'b00, rnd[65:32]});
   assign res   = 36'(base_ff) + delta;

   always_comb begin
      priority if (half_ff <= 0) begin
         res_sat = resp_ff;
      end else if (res > 36'sh0_7FFF_FFFF) begin
         res_sat = 32'h7FFF_FFFF;
      end else if (res < -36'sh0_8000_0000) begin
         res_sat = 32'h8000_0000;
      end else begin
         res_sat = res[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (take && vld_ff[NST-1]) begin
         out_ff <= res_sat;
      end
   end

   assign rsp_chan.valid          = out_vld_ff;
   assign rsp_chan.behavior_value = out_ff;

`ifndef ASSERT_OFF
   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      !adv |-> out_vld_ff && vld_ff[NST-1])
      else $error("pipeline held without a waiting result");
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      !adv |=> vld_ff[NST-1] && out_vld_ff && $stable(out_ff))
      else $error("held result changed");
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[Q_END] |-> quot <= 32'h8000_0000)
      else $error("quotient out of range");
   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[R_IDX] |-> r_ff <= 33'h1_0000_0000)
      else $error("ratio above one");
`endif

endmodule

FILE: sim/testbench.sv
// Testbench for the Hill response evaluator: directed table, random requests, scoreboard.
`timescale 1ns / 100ps

module testbench;
   import hre_pkg::*;

   localparam int LATENCY = 87;
   localparam int N_RANDOM = 1250;
   localparam int LB = LOG_BITS;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_idx = CSR_BASE;
   logic [DATA_W-1:0] csr_wdata = '0;

   hre_req_if req_chan ();
   hre_rsp_if rsp_chan ();

   hill_response_evaluator_top u_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // local copy of the registers
   logic signed [31:0] m_base = 0;
   logic signed [31:0] m_resp = 0;
   logic signed [31:0] m_half = 32'sd65536;
   logic [15:0] m_power = 16'd4096;
   logic m_incr = 1'b1;

   logic signed [31:0] behaviour_q[$];
   int errors = 0;
   int sent = 0;
   int received = 0;
   int stall_left = 0;    // receiver idle cycles still to run
   bit quiet = 1'b0;      // last part of the run: no idling
   bit hold_rsp = 1'b0;   // long receiver stall
   bit done = 1'b0;

   function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
      logic [63:0] v, r, b;
      v = v_in; r = '0; b = 64'h4000_0000_0000_0000;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // log2 of positive Q16.16, result Q6.24 signed
   function automatic longint log2_q(input logic [63:0] x);
      int p;
      logic [63:0] m;
      longint frac;
      p = 30; frac = 0;
      while (p > 0 && x[p] == 1'b0) p--;
      m = x << (31 - p);
      for (int k = 0; k < LB; k++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      return longint'(p - FRAC_BITS) * (longint'(1) << LB) + frac;
   endfunction

   // 2^(f/2^24) as Q1.31
   function automatic logic [63:0] pow2_frac(input logic [63:0] f);
      logic [63:0] c, m;
      c = 64'h1_0000_0000; m = 64'h8000_0000;
      for (int k = 1; k <= LB; k++) begin
         c = int_sqrt(c << 31);
         if (f[LB-k]) m = (m * c) >> 31;
      end
      return m;
   endfunction

   function automatic logic signed [31:0] hill_behaviour(input logic signed [31:0] sig);
      longint s, l, diff, delta, res;
      logic [63:0] r, u, dm, ip, q, m, den, mag, prod;
      bit neg;
      if (m_half <= 0) return m_resp;
      s = (sig < 0) ? 0 : longint'(sig);
      if (s == 0) begin
         r = (m_power == 0) ? 64'h8000_0000 : 64'd0;
      end else begin
         l = log2_q(64'(m_half)) - log2_q(64'(s));
         neg = l < 0;
         u = neg ? 64'(-l) : 64'(l);
         dm = (u * 64'(m_power)) >> POWER_FRAC_BITS;
         ip = dm >> LB;
         if (ip >= 32) begin
            q = 0;
         end else begin
            m = pow2_frac(dm & ((64'd1 << LB) - 1));
            den = 64'h8000_0000 + (m << ip);
            q = (64'd1 << 63) / den;
         end
         r = neg ? ((64'd1 << 32) - q) : q;
      end
      diff = longint'(m_resp) - longint'(m_base);
      mag = diff < 0 ? 64'(-diff) : 64'(diff);
      prod = (mag * r + 64'h8000_0000) >> 32;
      delta = diff < 0 ? -longint'(prod) : longint'(prod);
      res = longint'(m_base) + delta;
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      return res[31:0];
   endfunction

   task automatic write_reg(input csr_idx_type idx, input logic [31:0] val);
      csr_we <= 1'b1; csr_idx <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BASE:       m_base = val;
         CSR_RESPONSE:   m_resp = val;
         CSR_HALF_MAX:   m_half = val;
         CSR_HILL_POWER: m_power = val[15:0];
         default:        m_incr = val[0];
      endcase
   endtask

   task automatic set_all(input logic [31:0] b, input logic [31:0] rv, input logic [31:0] k,
                          input logic [15:0] n, input bit inc);
      write_reg(CSR_BASE, b);
      write_reg(CSR_RESPONSE, rv);
      write_reg(CSR_HALF_MAX, k);
      write_reg(CSR_HILL_POWER, {16'd0, n});
      write_reg(CSR_INCREASING, {31'd0, inc});
   endtask

   // wait for every expected response, then let the pipeline run empty
   task automatic drain();
      wait (behaviour_q.size() == 0);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   // one request; expected value either typed in or predicted
   task automatic send(input logic [31:0] sig, input bit has_exp, input logic [31:0] exp_v);
      logic [31:0] exp_now;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.signal_value <= sig;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      exp_now = has_exp ? exp_v : hill_behaviour(sig);
      behaviour_q.insert(behaviour_q.size(), exp_now);
      sent++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_signal();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 32'h0004_0000);
         2: return 32'h0001_0000 + $urandom_range(0, 32'h2000) - 32'h1000;
         3: return $urandom_range(0, 255);
         4: return 32'h1 << $urandom_range(0, 30);
         default: return $urandom_range(0, 32'h0100_0000);
      endcase
   endfunction

   typedef struct {
      logic [31:0] sig;
      bit has_exp;
      logic [31:0] exp_v;
   } stim_row_type;

   // directed table under the reset settings and a few chosen ones
   stim_row_type reset_rows[] = '{
      '{32'h0001_0000, 1'b1, 32'h0},   // reset: base = response = 0
      '{32'h8000_0000, 1'b1, 32'h0},   // most negative clamps to zero
      '{32'h7FFF_FFFF, 1'b1, 32'h0},
      '{32'h0000_0000, 1'b1, 32'h0}
   };
   stim_row_type wide_rows[] = '{
      '{32'h0000_0000, 1'b1, 32'h8000_0000},  // zero signal, n > 0: base
      '{32'hFFFF_FFFF, 1'b1, 32'h8000_0000},  // negative clamps: base
      '{32'h7FFF_FFFF, 1'b0, 32'h0},          // huge signal, ratio near 1
      '{32'h0000_0001, 1'b0, 32'h0},
      '{32'h0001_0000, 1'b0, 32'h0},          // s == K: half way
      '{32'h5555_5555, 1'b0, 32'h0},
      '{32'hAAAA_AAAA, 1'b1, 32'h8000_0000}
   };

   // receiver: random idle bursts, one long hold
   always @(negedge clock) begin
      if (reset || hold_rsp) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = $urandom_range(0, 18);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // compare against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         received++;
         if (behaviour_q.size() == 0) begin
            $error("behavior_value: response with no request waiting, actual %h",
                   rsp_chan.behavior_value);
            errors++;
         end else begin
            logic [31:0] e;
            e = behaviour_q.pop_front();
            if (rsp_chan.behavior_value !== e) begin
               $error("behavior_value: expected %h actual %h", e, rsp_chan.behavior_value);
               errors++;
            end
         end
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.signal_value = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (reset_rows[i]) send(reset_rows[i].sig, reset_rows[i].has_exp, reset_rows[i].exp_v);
      req_chan.valid <= 1'b0;
      drain();

      // extremes of base and response
      set_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 16'hFFFF, 1'b0);
      foreach (wide_rows[i]) send(wide_rows[i].sig, wide_rows[i].has_exp, wide_rows[i].exp_v);
      req_chan.valid <= 1'b0;
      drain();

      // zero exponent: half way for any signal, zero included
      set_all(32'h0000_0000, 32'h0004_0000, 32'h0002_0000, 16'h0000, 1'b1);
      send(32'h0000_0000, 1'b1, 32'h0002_0000);
      send(32'h7FFF_FFFF, 1'b1, 32'h0002_0000);
      send(32'h8000_0000, 1'b1, 32'h0002_0000);
      req_chan.valid <= 1'b0;
      drain();

      // half-max not positive: step to response
      set_all(32'h1234_5678, 32'hFEDC_BA98, 32'h0000_0000, 16'h1000, 1'b1);
      send(32'h0001_0000, 1'b1, 32'hFEDC_BA98);
      req_chan.valid <= 1'b0;
      drain();
      write_reg(CSR_HALF_MAX, 32'h8000_0000);
      send(32'h0000_0000, 1'b1, 32'hFEDC_BA98);
      send(32'h7FFF_FFFF, 1'b1, 32'hFEDC_BA98);
      req_chan.valid <= 1'b0;
      drain();

      // largest half-max, smallest signal: huge exponent term
      set_all(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 16'hF000, 1'b0);
      send(32'h0000_0001, 1'b0, 32'h0);
      send(32'h7FFF_FFFF, 1'b0, 32'h0);
      req_chan.valid <= 1'b0;
      drain();

      // random phases with fresh settings each time
      for (int ph = 0; ph < 10; ph++) begin
         logic [31:0] k;
         logic [15:0] n;
         k = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 32'h0010_0000);
         n = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h4000));
         set_all($urandom, $urandom, k, n, 1'($urandom_range(0, 1)));
         if (ph == 9) quiet = 1'b1;
         if (ph == 4) begin
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (600) @(negedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         for (int i = 0; i < N_RANDOM / 10; i++) send(rand_signal(), 1'b0, 32'h0);
         req_chan.valid <= 1'b0;
         drain();
      end
      done = 1'b1;
   end

   initial begin
      wait (done);
      if (errors == 0 && behaviour_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         if (behaviour_q.size() != 0) begin
            $error("behavior_value: %0d responses missing", behaviour_q.size());
         end
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: hill_response_evaluator_top.f
rtl/hre_pkg.sv
rtl/hre_if.sv
rtl/hre_log2_lane.sv
rtl/hre_divider.sv
rtl/hill_response_evaluator_top.sv
sim/testbench.sv
